[rtl/core/civil_date_to_unix_seconds_unit_assert.svh]
// Assertion macros used by the checker module of the date-to-seconds unit
`ifndef CIVIL_DATE_TO_UNIX_SECONDS_UNIT_ASSERT_SVH
`define CIVIL_DATE_TO_UNIX_SECONDS_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define CDUS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define CDUS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/cdus_pkg.sv]
// Shared types, constants and tables of the date-to-seconds unit
package cdus_pkg;

    localparam int YearW     = 14;
    localparam int MonthW    = 4;
    localparam int DayW      = 5;
    localparam int HourW     = 5;
    localparam int MinuteW   = 6;
    localparam int SecondW   = 6;
    localparam int SecondsW  = 32;

    localparam int ShYearW   = 15;
    localparam int QuartW    = 13;
    localparam int DoyW      = 10;
    localparam int TodW      = 17;
    localparam int DaysW     = 24;
    localparam int CentW     = 9;
    localparam int RecipW    = 26;
    localparam int WideW     = 41;

    // year shifted by one era so that floor divisions stay non-negative
    localparam logic [ShYearW-1:0] EraYears     = 15'd400;
    // 719468 + 146097 compensates the era added above
    localparam logic [DaysW-1:0]   EpochDays    = 24'd865565;
    localparam logic [QuartW-1:0]  Recip25      = 13'd5243;
    localparam int                 Recip25Shift = 17;
    localparam logic [TodW-1:0]    SecPerHour   = 17'd3600;
    localparam logic [TodW-1:0]    SecPerMinute = 17'd60;
    localparam logic [DaysW-1:0]   DaysPerYear  = 24'd365;
    localparam logic signed [WideW-1:0] SecPerDay = 41'sd86400;

    typedef struct packed {
        logic                    valid;
        logic                    ok;
        logic signed [DaysW-1:0] days;
        logic [TodW-1:0]         tod;
    } t_day_item;

    // days from March 1 to the first of the given month, March-based year
    function automatic logic [8:0] days_before_month(input logic [MonthW-1:0] month);
        logic [8:0] v;
        case (month)
            4'd0:    v = 9'd275;
            4'd1:    v = 9'd306;
            4'd2:    v = 9'd337;
            4'd3:    v = 9'd0;
            4'd4:    v = 9'd31;
            4'd5:    v = 9'd61;
            4'd6:    v = 9'd92;
            4'd7:    v = 9'd122;
            4'd8:    v = 9'd153;
            4'd9:    v = 9'd184;
            4'd10:   v = 9'd214;
            4'd11:   v = 9'd245;
            4'd12:   v = 9'd275;
            4'd13:   v = 9'd306;
            4'd14:   v = 9'd337;
            default: v = 9'd367;
        endcase
        return v;
    endfunction

endpackage

[rtl/core/civil_date_to_unix_seconds_unit.sv]
// Top level of the civil date to Unix seconds unit
//
//   channel  | handshake           | payload
//   ---------+---------------------+------------------------------------------
//   input    | i_valid / o_ready   | year, month, day, hour, minute, second, flags
//   output   | o_valid / i_ready   | unix_seconds
//
// Five register stages; one transaction per cycle while the output side is not stalled.
// The 24x17 day-to-second multiply in stage four sets the stage depth.
// Synchronous active-low reset clears the valid bits only.
// The whole pipeline holds while the output transaction waits; bubbles are kept.
module civil_date_to_unix_seconds_unit
    import cdus_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [YearW-1:0]    i_year,
    input  logic [MonthW-1:0]   i_month,
    input  logic [DayW-1:0]     i_day,
    input  logic [HourW-1:0]    i_hour,
    input  logic [MinuteW-1:0]  i_minute,
    input  logic [SecondW-1:0]  i_second,
    input  logic                i_date_valid,
    input  logic                i_time_valid,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [SecondsW-1:0] o_unix_seconds
);

    logic      s_en;
    t_day_item s_item;

    assign s_en    = !o_valid || i_ready;
    assign o_ready = s_en;

    cdus_day_pipe u_day (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (s_en),
        .i_valid      (i_valid),
        .i_year       (i_year),
        .i_month      (i_month),
        .i_day        (i_day),
        .i_hour       (i_hour),
        .i_minute     (i_minute),
        .i_second     (i_second),
        .i_date_valid (i_date_valid),
        .i_time_valid (i_time_valid),
        .o_item       (s_item)
    );

    cdus_sec_pipe u_sec (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (s_en),
        .i_item    (s_item),
        .o_valid   (o_valid),
        .o_seconds (o_unix_seconds)
    );

endmodule

[rtl/core/cdus_day_pipe.sv]
// Three-stage day-count pipeline: shifted year, reciprocal divide, day sum
module cdus_day_pipe
    import cdus_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [YearW-1:0]   i_year,
    input  logic [MonthW-1:0]  i_month,
    input  logic [DayW-1:0]    i_day,
    input  logic [HourW-1:0]   i_hour,
    input  logic [MinuteW-1:0] i_minute,
    input  logic [SecondW-1:0] i_second,
    input  logic               i_date_valid,
    input  logic               i_time_valid,
    output t_day_item          o_item
);

    logic                    r1_valid, r2_valid, r3_valid;
    logic                    r1_ok, r2_ok, r3_ok;
    logic [ShYearW-1:0]      r1_year;
    logic signed [DoyW-1:0]  r1_doy;
    logic [TodW-1:0]         r1_tod, r2_tod, r3_tod;
    logic [RecipW-1:0]       r2_prod;
    logic signed [DaysW-1:0] r2_base;
    logic signed [DaysW-1:0] r3_days;

    logic [ShYearW-1:0]      n1_year;
    logic signed [DoyW-1:0]  n1_doy;
    logic [TodW-1:0]         n1_tod;
    logic [QuartW-1:0]       s2_quart;
    logic [RecipW-1:0]       n2_prod;
    logic signed [DaysW-1:0] n2_base;
    logic [CentW-1:0]        s3_cent;
    logic signed [DaysW-1:0] n3_days;

    always_comb begin
        n1_year = {1'b0, i_year} + EraYears - ShYearW'(i_month <= 4'd2);
        n1_doy  = $signed({1'b0, days_before_month(i_month)})
                + $signed({5'b0, i_day}) - 10'sd1;
        n1_tod  = TodW'(i_hour) * SecPerHour + TodW'(i_minute) * SecPerMinute
                + TodW'(i_second);
    end

    always_comb begin
        s2_quart = r1_year[ShYearW-1:2];
        n2_prod  = RecipW'(s2_quart) * RecipW'(Recip25);
        n2_base  = $signed(DaysW'(r1_year) * DaysPerYear) + $signed(DaysW'(s2_quart))
                 + $signed({{(DaysW-DoyW){r1_doy[DoyW-1]}}, r1_doy});
    end

    // year/100 and year/400 both come from the quarter-year divided by 25
    always_comb begin
        s3_cent = r2_prod[Recip25Shift +: CentW];
        n3_days = r2_base - $signed(DaysW'(s3_cent)) + $signed(DaysW'(s3_cent >> 2))
                - $signed(EpochDays);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ok   <= i_date_valid & i_time_valid;
            r1_year <= n1_year;
            r1_doy  <= n1_doy;
            r1_tod  <= n1_tod;
            r2_ok   <= r1_ok;
            r2_tod  <= r1_tod;
            r2_prod <= n2_prod;
            r2_base <= n2_base;
            r3_ok   <= r2_ok;
            r3_tod  <= r2_tod;
            r3_days <= n3_days;
        end
    end

    assign o_item = '{valid: r3_valid, ok: r3_ok, days: r3_days, tod: r3_tod};

endmodule

[rtl/core/cdus_sec_pipe.sv]
// Two-stage seconds pipeline: scale days, add time of day, range check
module cdus_sec_pipe
    import cdus_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  t_day_item           i_item,
    output logic                o_valid,
    output logic [SecondsW-1:0] o_seconds
);

    logic                    r4_valid, r5_valid;
    logic                    r4_ok;
    logic [TodW-1:0]         r4_tod;
    logic signed [WideW-1:0] r4_prod;
    logic [SecondsW-1:0]     r5_seconds;

    logic signed [WideW-1:0] n4_prod;
    logic signed [WideW-1:0] s5_sum;
    logic                    s5_in_range;
    logic [SecondsW-1:0]     n5_seconds;

    always_comb begin
        n4_prod = $signed({{(WideW-DaysW){i_item.days[DaysW-1]}}, i_item.days}) * SecPerDay;
    end

    always_comb begin
        s5_sum      = r4_prod + $signed({{(WideW-TodW){1'b0}}, r4_tod});
        s5_in_range = !s5_sum[WideW-1] && (s5_sum != '0)
                    && (s5_sum[WideW-1:SecondsW] == '0);
        n5_seconds  = (r4_ok && s5_in_range) ? s5_sum[SecondsW-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else if (i_en) begin
            r4_valid <= i_item.valid;
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_ok      <= i_item.ok;
            r4_tod     <= i_item.tod;
            r4_prod    <= n4_prod;
            r5_seconds <= n5_seconds;
        end
    end

    assign o_valid   = r5_valid;
    assign o_seconds = r5_seconds;

endmodule

[rtl/core/cdus_assert_chk.sv]
// Port-level checker of the date-to-seconds unit and its bind
`include "civil_date_to_unix_seconds_unit_assert.svh"

module cdus_assert_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [13:0] i_year,
    input logic [3:0]  i_month,
    input logic [4:0]  i_day,
    input logic [4:0]  i_hour,
    input logic [5:0]  i_minute,
    input logic [5:0]  i_second,
    input logic        i_date_valid,
    input logic        i_time_valid,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_unix_seconds
);

    `CDUS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_unix_seconds), "output changed while stalled")
    `CDUS_ASSERT_NOW(a_ready_when_drained, i_clk, i_rst_n, i_ready, o_ready, "input blocked while output side is ready")
    `CDUS_ASSERT_NEXT(a_latency, i_clk, i_rst_n, (i_valid && o_ready) ##1 i_ready ##1 i_ready ##1 i_ready ##1 i_ready, o_valid, "result missing after five free-running cycles")
    `CDUS_ASSERT_NEXT(a_flag_zero, i_clk, i_rst_n, (i_valid && o_ready && (!i_date_valid || !i_time_valid)) ##1 i_ready ##1 i_ready ##1 i_ready ##1 i_ready, o_valid && (o_unix_seconds == 32'd0), "invalid flags gave a nonzero result")

endmodule

bind civil_date_to_unix_seconds_unit cdus_assert_chk u_cdus_assert_chk (.*);
